// ----- rtl/swtm_pkg.sv -----
// Shared constants and types for the sliding-window trimmed-mean filter.
`default_nettype none
package swtm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WINDOW_DEF  = 100;
    localparam int TRIM_DEF    = 10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_RD,
        S_FILL_WR,
        S_LOAD,
        S_VI,
        S_CMP,
        S_DIV_GO,
        S_DIV_WAIT
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/swtm_win.sv -----
// Sample window storage with registered read and per-entry valid bits.
`default_nettype none
module swtm_win #(
    parameter int WINDOW = swtm_pkg::WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [$clog2(WINDOW)-1:0]     i_waddr,
    input  wire logic [swtm_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic [$clog2(WINDOW)-1:0]     i_raddr,
    output logic      [swtm_pkg::SAMPLE_W-1:0] o_rdata
);

    logic [swtm_pkg::SAMPLE_W-1:0] r_mem [WINDOW];
    logic [WINDOW-1:0]             r_vld;
    logic [swtm_pkg::SAMPLE_W-1:0] r_rdata;
    logic                          r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    // An entry that was never written reads as the empty marker.
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule
`default_nettype wire

// ----- rtl/swtm_div.sv -----
// Division of the window sum by the fixed kept count through a reciprocal multiply.
`default_nettype none
module swtm_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR    = 80
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [DIVIDEND_W-1:0]         i_dividend,
    output logic                               o_busy,
    output logic      [swtm_pkg::SAMPLE_W-1:0] o_quotient
);

    localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
    localparam int RECIP_W = DIVIDEND_W + 2;
    localparam int PROD_W  = DIVIDEND_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  r_prod;
    logic               r_busy;

    assign recip = RECIP_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    // The reciprocal is rounded up, which keeps the truncated quotient exact over
    // the whole dividend range.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_dividend) * PROD_W'(recip);
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_prod[SHIFT +: swtm_pkg::SAMPLE_W];

endmodule
`default_nettype wire

// ----- rtl/sliding_window_trimmed_mean.sv -----
// Top level of the sliding-window trimmed-mean filter with its sequencer.
//
//  Channel  Signals                                   Direction
//  input    i_in_valid, o_in_ready, i_raw_word        in
//  output   o_out_valid, i_out_ready, o_filtered_value out
//
// The rank count, one comparator over all window pairs through one read port, dominates the work.
// Reset is synchronous and clears the window to empty.
// The next item is taken while a finished result still waits in the output
// register; a stalled output only holds the final divide step.
`default_nettype none
module sliding_window_trimmed_mean #(
    parameter int WINDOW = swtm_pkg::WINDOW_DEF,
    parameter int TRIM   = swtm_pkg::TRIM_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [swtm_pkg::SAMPLE_W-1:0] i_raw_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [swtm_pkg::SAMPLE_W-1:0] o_filtered_value
);

    localparam int IDX_W    = $clog2(WINDOW);
    localparam int RANK_W   = IDX_W + 1;
    localparam int SUM_W    = swtm_pkg::SAMPLE_W + IDX_W;
    localparam int TRIM_EFF = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
    localparam int KEPT     = WINDOW - 2 * TRIM_EFF;

    swtm_pkg::t_state r_state, n_state;

    logic [swtm_pkg::SAMPLE_W-1:0] r_sample;
    logic [swtm_pkg::SAMPLE_W-1:0] r_vi;
    logic [IDX_W-1:0]              r_head;
    logic [IDX_W-1:0]              r_p;
    logic [IDX_W-1:0]              r_i;
    logic [IDX_W-1:0]              r_j;
    logic [RANK_W-1:0]             r_rank;
    logic [SUM_W-1:0]              r_sum;
    logic                          r_out_valid;
    logic [swtm_pkg::SAMPLE_W-1:0] r_out_data;

    logic                          we;
    logic [IDX_W-1:0]              raddr;
    logic [swtm_pkg::SAMPLE_W-1:0] rdata;
    logic                          div_start;
    logic                          div_busy;
    logic [swtm_pkg::SAMPLE_W-1:0] quotient;
    logic                          in_xfer;
    logic                          out_free;
    logic                          p_last;
    logic                          i_last;
    logic                          j_last;
    logic                          less;
    logic [RANK_W-1:0]             rank_tot;
    logic                          keep;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign p_last   = r_p == IDX_W'(WINDOW - 1);
    assign i_last   = r_i == IDX_W'(WINDOW - 1);
    assign j_last   = r_j == IDX_W'(WINDOW - 1);
    assign less     = (rdata < r_vi) || ((rdata == r_vi) && (r_j < r_i));
    assign rank_tot = r_rank + RANK_W'(less);
    assign keep     = (rank_tot >= RANK_W'(TRIM_EFF))
                   && (rank_tot < RANK_W'(WINDOW - TRIM_EFF));

    swtm_win #(
        .WINDOW (WINDOW)
    ) u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (r_p),
        .i_wdata (r_sample),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    swtm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (KEPT)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            swtm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = swtm_pkg::S_FILL_RD;
                end
            end
            swtm_pkg::S_FILL_RD: n_state = swtm_pkg::S_FILL_WR;
            swtm_pkg::S_FILL_WR: begin
                n_state = p_last ? swtm_pkg::S_LOAD : swtm_pkg::S_FILL_RD;
            end
            swtm_pkg::S_LOAD: n_state = swtm_pkg::S_VI;
            swtm_pkg::S_VI:   n_state = swtm_pkg::S_CMP;
            swtm_pkg::S_CMP: begin
                if (j_last) begin
                    n_state = i_last ? swtm_pkg::S_DIV_GO : swtm_pkg::S_LOAD;
                end
            end
            swtm_pkg::S_DIV_GO: n_state = swtm_pkg::S_DIV_WAIT;
            swtm_pkg::S_DIV_WAIT: begin
                if (!div_busy && out_free) begin
                    n_state = swtm_pkg::S_IDLE;
                end
            end
            default: n_state = swtm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        we         = 1'b0;
        raddr      = r_p;
        div_start  = 1'b0;
        case (r_state)
            swtm_pkg::S_IDLE:    o_in_ready = i_rst_n;
            swtm_pkg::S_FILL_RD: raddr = r_p;
            swtm_pkg::S_FILL_WR: begin
                // The oldest slot takes the new sample; empty slots are filled too.
                we = (rdata == '0) || (r_p == r_head);
            end
            swtm_pkg::S_LOAD: raddr = r_i;
            swtm_pkg::S_VI:   raddr = '0;
            swtm_pkg::S_CMP:  raddr = j_last ? '0 : r_j + 1'b1;
            swtm_pkg::S_DIV_GO: div_start = 1'b1;
            swtm_pkg::S_DIV_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swtm_pkg::S_IDLE;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == swtm_pkg::S_FILL_WR && p_last) begin
                r_head <= (r_head == IDX_W'(WINDOW - 1)) ? '0 : r_head + 1'b1;
            end
            if (r_state == swtm_pkg::S_DIV_WAIT && !div_busy && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            swtm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_sample <= {i_raw_word[7:0], i_raw_word[15:8]};
                    r_p      <= '0;
                    r_i      <= '0;
                    r_sum    <= '0;
                end
            end
            swtm_pkg::S_FILL_WR: begin
                if (!p_last) begin
                    r_p <= r_p + 1'b1;
                end
            end
            swtm_pkg::S_VI: begin
                r_vi   <= rdata;
                r_j    <= '0;
                r_rank <= '0;
            end
            swtm_pkg::S_CMP: begin
                r_rank <= rank_tot;
                if (j_last) begin
                    if (keep) begin
                        r_sum <= r_sum + SUM_W'(r_vi);
                    end
                    if (!i_last) begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            swtm_pkg::S_DIV_WAIT: begin
                if (!div_busy && out_free) begin
                    r_out_data <= quotient;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_data;

endmodule
`default_nettype wire
